// ===== hdl/swl_pkg.sv =====
`default_nettype none
package swl_pkg;
  localparam int unsigned STORE_WORDS = 1024;
  localparam int unsigned AW          = 10;
  localparam int unsigned CACHE_WORDS = 16;
  localparam int unsigned CIW         = 4;
  localparam int unsigned CFW         = 5;
  localparam int unsigned WB          = 16;

  localparam logic [2:0] ACT_READ  = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_FLUSH = 3'd2;
  localparam logic [2:0] ACT_REMAP = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;
endpackage
`default_nettype wire

// ===== hdl/shift_wear_leveler_with_write_cache.sv =====
// channel  dir  tdata                               tuser
// s_axis   in   [9:0] address [25:10] write_data    [2:0] action
//               [35:26] shift [39:36] zero
// m_axis   out  [15:0] result_data                  [0] cache_hit
// Read/write: cache entries are scanned in order until a hit. On a miss a full
// cache is first written back (write-back walk); a read miss then reads the store.
// Flush: dirty entries are written back. Remap: flush, plus two copy sweeps
// through the scratch memory when shift != 0. Clear: every store word is zeroed.
// Reset: async, active low; store contents are not cleared.
// A finished response waits in the output register; input is taken meanwhile.
`default_nettype none
module shift_wear_leveler_with_write_cache (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // address, write_data, shift
  input  wire logic [2:0]  s_axis_tuser_i,  // action
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // result_data
  output logic [0:0]       m_axis_tuser_o   // cache_hit
);
  localparam int unsigned AW  = swl_pkg::AW;
  localparam int unsigned CIW = swl_pkg::CIW;
  localparam int unsigned CFW = swl_pkg::CFW;
  localparam int unsigned WB  = swl_pkg::WB;
  localparam int unsigned CW  = swl_pkg::CACHE_WORDS;
  localparam logic [AW:0] NW  = (AW+1)'(swl_pkg::STORE_WORDS);
  localparam logic [CFW-1:0] CFULL = CFW'(CW);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_MISS, ST_RDWAIT, ST_FLUSH, ST_REMAP,
    ST_ROTA, ST_ROTB, ST_CLR, ST_RESP
  } state_e;

  state_e state_q, ret_q;
  logic [2:0]     act_q;
  logic [AW-1:0]  phys_q, shift_q, offset_q;
  logic [WB-1:0]  wdata_q, res_data_q, out_data_q;
  logic           res_hit_q, out_hit_q, out_valid_q;
  logic [CFW-1:0] idx_q, fill_q;
  logic [CW-1:0]  dirty_q;
  logic [AW:0]    cnt_q;

  logic [AW-1:0]  tags_q  [CW];
  logic [WB-1:0]  words_q [CW];
  logic [WB-1:0]  mem [swl_pkg::STORE_WORDS];
  logic [WB-1:0]  scr [swl_pkg::STORE_WORDS];
  logic [WB-1:0]  mem_rd_q, scr_rd_q;

  logic [CIW-1:0] ci;
  logic           scan_end, tag_hit, accept;
  logic           mem_we, scr_we, cw_en;
  logic [AW-1:0]  mem_waddr, mem_raddr, scr_waddr, scr_raddr;
  logic [WB-1:0]  mem_wdata, scr_wdata, cw_word;
  logic [CIW-1:0] cw_idx;

  assign ci       = idx_q[CIW-1:0];
  assign scan_end = (idx_q == fill_q);
  assign tag_hit  = !scan_end && (tags_q[ci] == phys_q);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_hit_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = '0;
    mem_raddr = phys_q;
    scr_we    = 1'b0;
    scr_waddr = cnt_q[AW-1:0] - AW'(1);
    scr_wdata = mem_rd_q;
    scr_raddr = cnt_q[AW-1:0];
    cw_en     = 1'b0;
    cw_idx    = fill_q[CIW-1:0];
    cw_word   = wdata_q;
    case (state_q)
      ST_FLUSH: begin
        mem_we    = !scan_end && dirty_q[ci];
        mem_waddr = tags_q[ci];
        mem_wdata = words_q[ci];
      end
      ST_CLR: begin
        mem_we = 1'b1;
      end
      ST_ROTA: begin
        mem_raddr = cnt_q[AW-1:0] + shift_q;
        scr_we    = (cnt_q != '0);
      end
      ST_ROTB: begin
        mem_we    = (cnt_q != '0);
        mem_waddr = cnt_q[AW-1:0] - AW'(1);
        mem_wdata = scr_rd_q;
      end
      ST_LOOK: begin
        cw_en  = tag_hit && (act_q == swl_pkg::ACT_WRITE);
        cw_idx = ci;
      end
      ST_MISS: begin
        cw_en = (fill_q != CFULL) && (act_q == swl_pkg::ACT_WRITE);
      end
      ST_RDWAIT: begin
        cw_en   = 1'b1;
        cw_word = mem_rd_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) begin
      scr[scr_waddr] <= scr_wdata;
    end
    scr_rd_q <= scr[scr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cw_en) begin
      tags_q[cw_idx]  <= phys_q;
      words_q[cw_idx] <= cw_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      act_q       <= '0;
      phys_q      <= '0;
      shift_q     <= '0;
      offset_q    <= '0;
      wdata_q     <= '0;
      res_data_q  <= '0;
      res_hit_q   <= 1'b0;
      out_data_q  <= '0;
      out_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      fill_q      <= '0;
      dirty_q     <= '0;
      cnt_q       <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            act_q      <= s_axis_tuser_i;
            phys_q     <= s_axis_tdata_i[AW-1:0] - offset_q;
            wdata_q    <= s_axis_tdata_i[25:10];
            shift_q    <= s_axis_tdata_i[35:26];
            res_data_q <= '0;
            res_hit_q  <= 1'b0;
            idx_q      <= '0;
            cnt_q      <= '0;
            case (s_axis_tuser_i)
              swl_pkg::ACT_READ, swl_pkg::ACT_WRITE: state_q <= ST_LOOK;
              swl_pkg::ACT_FLUSH: begin
                ret_q   <= ST_RESP;
                state_q <= ST_FLUSH;
              end
              swl_pkg::ACT_REMAP: begin
                offset_q <= offset_q + s_axis_tdata_i[35:26];
                ret_q    <= ST_REMAP;
                state_q  <= ST_FLUSH;
              end
              swl_pkg::ACT_CLEAR: begin
                fill_q  <= '0;
                dirty_q <= '0;
                state_q <= ST_CLR;
              end
              default: state_q <= ST_RESP;
            endcase
          end
        end
        ST_LOOK: begin
          if (scan_end) begin
            state_q <= ST_MISS;
          end else if (tag_hit) begin
            res_hit_q <= 1'b1;
            if (act_q == swl_pkg::ACT_WRITE) begin
              dirty_q[ci] <= 1'b1;
              res_data_q  <= wdata_q;
            end else begin
              res_data_q <= words_q[ci];
            end
            state_q <= ST_RESP;
          end else begin
            idx_q <= idx_q + CFW'(1);
          end
        end
        ST_MISS: begin
          if (fill_q == CFULL) begin
            idx_q   <= '0;
            ret_q   <= ST_MISS;
            state_q <= ST_FLUSH;
          end else if (act_q == swl_pkg::ACT_WRITE) begin
            dirty_q[fill_q[CIW-1:0]] <= 1'b1;
            fill_q     <= fill_q + CFW'(1);
            res_data_q <= wdata_q;
            state_q    <= ST_RESP;
          end else begin
            state_q <= ST_RDWAIT;
          end
        end
        ST_RDWAIT: begin
          dirty_q[fill_q[CIW-1:0]] <= 1'b0;
          fill_q     <= fill_q + CFW'(1);
          res_data_q <= mem_rd_q;
          state_q    <= ST_RESP;
        end
        ST_FLUSH: begin
          if (scan_end) begin
            fill_q  <= '0;
            state_q <= ret_q;
          end else begin
            dirty_q[ci] <= 1'b0;
            idx_q       <= idx_q + CFW'(1);
          end
        end
        ST_REMAP: begin
          cnt_q   <= '0;
          state_q <= (shift_q == '0) ? ST_RESP : ST_ROTA;
        end
        ST_ROTA: begin
          if (cnt_q == NW) begin
            cnt_q   <= '0;
            state_q <= ST_ROTB;
          end else begin
            cnt_q <= cnt_q + (AW+1)'(1);
          end
        end
        ST_ROTB: begin
          if (cnt_q == NW) begin
            state_q <= ST_RESP;
          end else begin
            cnt_q <= cnt_q + (AW+1)'(1);
          end
        end
        ST_CLR: begin
          if (cnt_q == NW - (AW+1)'(1)) begin
            state_q <= ST_RESP;
          end else begin
            cnt_q <= cnt_q + (AW+1)'(1);
          end
        end
        ST_RESP: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_data_q;
            out_hit_q   <= res_hit_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CFULL) else $error("cache fill above capacity");
  a_dirty_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dirty_q & ({CW{1'b1}} << fill_q)) == '0) else $error("dirty bit on empty entry");
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o) else $error("ready right after request");
`endif
endmodule
`default_nettype wire

// ===== sim/swl_checker.sv =====
`default_nettype none
module swl_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [39:0] s_axis_tdata_i,
  input  wire logic [2:0]  s_axis_tuser_i,
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [15:0] m_axis_tdata_i,
  input  wire logic [0:0]  m_axis_tuser_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [swl_pkg::WB-1:0] word;
    logic                   hit;
  } access_rsp_t;

  logic [swl_pkg::WB-1:0]  store_mem [swl_pkg::STORE_WORDS];
  logic [swl_pkg::WB-1:0]  line_word [swl_pkg::CACHE_WORDS];
  logic [swl_pkg::AW-1:0]  line_tag  [swl_pkg::CACHE_WORDS];
  bit                      line_dirty[swl_pkg::CACHE_WORDS];
  int                      line_count;
  logic [swl_pkg::AW-1:0]  rot_offset;
  access_rsp_t             rsp_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    line_count   = 0;
    rot_offset   = '0;
    foreach (line_dirty[k]) line_dirty[k] = 0;
  end

  function automatic void write_back_lines();
    for (int k = 0; k < line_count; k++) begin
      if (line_dirty[k]) store_mem[line_tag[k]] = line_word[k];
      line_dirty[k] = 0;
    end
    line_count = 0;
  endfunction

  function automatic int lookup_line(logic [swl_pkg::AW-1:0] phys);
    for (int k = 0; k < line_count; k++)
      if (line_tag[k] == phys) return k;
    return -1;
  endfunction

  function automatic void allocate_line(logic [swl_pkg::AW-1:0] phys,
                                        logic [swl_pkg::WB-1:0] w, bit dirty);
    if (line_count >= swl_pkg::CACHE_WORDS) write_back_lines();
    line_tag[line_count]   = phys;
    line_word[line_count]  = w;
    line_dirty[line_count] = dirty;
    line_count++;
  endfunction

  function automatic access_rsp_t serve_request(logic [2:0] act,
                                                logic [swl_pkg::AW-1:0] addr,
                                                logic [swl_pkg::WB-1:0] wdata,
                                                logic [swl_pkg::AW-1:0] amount);
    access_rsp_t             rsp;
    logic [swl_pkg::AW-1:0]  phys;
    logic [swl_pkg::WB-1:0]  rotated[swl_pkg::STORE_WORDS];
    int                      e;
    rsp  = '0;
    phys = addr - rot_offset;
    case (act)
      swl_pkg::ACT_READ: begin
        e = lookup_line(phys);
        if (e >= 0) begin
          rsp.hit  = 1'b1;
          rsp.word = line_word[e];
        end else begin
          rsp.word = store_mem[phys];
          allocate_line(phys, rsp.word, 0);
        end
      end
      swl_pkg::ACT_WRITE: begin
        e = lookup_line(phys);
        if (e >= 0) begin
          rsp.hit       = 1'b1;
          line_word[e]  = wdata;
          line_dirty[e] = 1;
        end else begin
          allocate_line(phys, wdata, 1);
        end
        rsp.word = wdata;
      end
      swl_pkg::ACT_FLUSH: write_back_lines();
      swl_pkg::ACT_REMAP: begin
        rot_offset = rot_offset + amount;
        write_back_lines();
        if (amount != 0) begin
          for (int p = 0; p < swl_pkg::STORE_WORDS; p++)
            rotated[p] = store_mem[(p + amount) % swl_pkg::STORE_WORDS];
          store_mem = rotated;
        end
      end
      swl_pkg::ACT_CLEAR: begin
        foreach (store_mem[p]) store_mem[p] = '0;
        foreach (line_word[k]) begin
          line_word[k]  = '0;
          line_dirty[k] = 0;
        end
        line_count = 0;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i) begin
    access_rsp_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        rsp_q.push_back(serve_request(s_axis_tuser_i, s_axis_tdata_i[9:0],
                                      s_axis_tdata_i[25:10], s_axis_tdata_i[35:26]));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (rsp_q.size() == 0) begin
          $error("response with no request outstanding: result_data %h cache_hit %b",
                 m_axis_tdata_i, m_axis_tuser_i);
          fail_count_o++;
        end else begin
          want = rsp_q.pop_front();
          if (m_axis_tdata_i !== want.word) begin
            $error("result_data mismatch: expected %h actual %h", want.word, m_axis_tdata_i);
            fail_count_o++;
          end
          if (m_axis_tuser_i[0] !== want.hit) begin
            $error("cache_hit mismatch: expected %b actual %b", want.hit, m_axis_tuser_i[0]);
            fail_count_o++;
          end
        end
      end
      pending_o = rsp_q.size();
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_REQS = 900;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic [2:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  int fail_count;
  int pending;
  int cycles;
  int hold_rx;
  int act_seen[5];
  int hits_seen;

  shift_wear_leveler_with_write_cache u_top (.*);

  swl_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tuser_i(m_axis_tuser_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (m_axis_tvalid_o && m_axis_tready_i && m_axis_tuser_o[0]) hits_seen++;
      if (cycles > CYCLE_LIMIT) begin
        $display("shift_wear_leveler_with_write_cache test failed");
        $finish;
      end
    end
  end

  // response side backpressure; hold_rx forces a long stall
  initial begin
    int stall;
    int r;
    stall = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      r = $urandom_range(0, 199);
      if (hold_rx > 0) begin
        hold_rx--;
        m_axis_tready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready_i <= 1'b0;
      end else if (r < 2) begin
        stall = $urandom_range(20, 80);
        m_axis_tready_i <= 1'b0;
      end else if (cycles % 2000 < 400) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= (r < 140);
      end
    end
  end

  task automatic send_req(logic [2:0] act, logic [9:0] addr, logic [15:0] wdata,
                          logic [9:0] amount);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= {4'b0, amount, wdata, addr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    act_seen[act]++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return;
    s_axis_tvalid_i <= 1'b0;
    if (r < 95) repeat ($urandom_range(1, 3)) @(negedge clk_i);
    else repeat ($urandom_range(20, 60)) @(negedge clk_i);
  endtask

  function automatic logic [9:0] pick_shift();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 10'd0;
    if (r == 1) return 10'd1022;
    if (r < 5) return 10'(($urandom_range(0, 63) * 2 + 1) << $urandom_range(0, 8));
    return 10'($urandom_range(0, 1022));
  endfunction

  initial begin
    logic [9:0] base;
    int         r;
    logic [2:0] act;
    logic [9:0] addr;
    hold_rx         = 0;
    hits_seen       = 0;
    foreach (act_seen[k]) act_seen[k] = 0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = swl_pkg::ACT_READ;
    rst_ni          = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // clear first so that no store word is read before it was written
    send_req(swl_pkg::ACT_CLEAR, 10'd0, 16'd0, 10'd0);
    send_req(swl_pkg::ACT_WRITE, 10'd0, 16'hffff, 10'd0);
    send_req(swl_pkg::ACT_WRITE, 10'd1023, 16'h0000, 10'd0);
    send_req(swl_pkg::ACT_READ, 10'd0, 16'd0, 10'd0);
    send_req(swl_pkg::ACT_READ, 10'd1023, 16'd0, 10'd0);
    send_req(swl_pkg::ACT_READ, 10'd5, 16'd0, 10'd0);
    for (int k = 0; k < 13; k++)
      send_req(swl_pkg::ACT_WRITE, 10'(100 + k), 16'(k * 16'h1111), 10'd0);
    send_req(swl_pkg::ACT_READ, 10'd300, 16'd0, 10'd0);          // read miss into a full cache
    for (int k = 0; k < 15; k++) send_req(swl_pkg::ACT_READ, 10'(400 + k), 16'd0, 10'd0);
    send_req(swl_pkg::ACT_WRITE, 10'h155, 16'haaaa, 10'd0);     // write miss into a full cache
    send_req(swl_pkg::ACT_FLUSH, 10'd0, 16'd0, 10'd0);
    send_req(swl_pkg::ACT_REMAP, 10'd0, 16'd0, 10'd0);
    send_req(swl_pkg::ACT_REMAP, 10'd0, 16'd0, 10'd1);
    send_req(swl_pkg::ACT_READ, 10'd0, 16'd0, 10'd0);
    send_req(swl_pkg::ACT_REMAP, 10'd0, 16'd0, 10'd1022);
    send_req(swl_pkg::ACT_REMAP, 10'd0, 16'd0, 10'd512);
    send_req(swl_pkg::ACT_READ, 10'h155, 16'd0, 10'd0);
    send_req(swl_pkg::ACT_WRITE, 10'h2aa, 16'h5555, 10'h3ff);

    // stall the response side while requests keep coming
    hold_rx = 400;
    for (int k = 0; k < 12; k++)
      send_req(swl_pkg::ACT_WRITE, 10'(k * 3), 16'($urandom), 10'd0);

    base = 10'($urandom);
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 2) begin
        s_axis_tvalid_i <= 1'b0;
        while (pending != 0) @(negedge clk_i);
        repeat (5) @(negedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r < 44) act = swl_pkg::ACT_READ;
      else if (r < 88) act = swl_pkg::ACT_WRITE;
      else if (r < 94) act = swl_pkg::ACT_FLUSH;
      else if (r < 98) act = swl_pkg::ACT_REMAP;
      else act = swl_pkg::ACT_CLEAR;
      if ($urandom_range(0, 49) == 0) base = 10'($urandom);
      if ($urandom_range(0, 9) < 7) addr = base + 10'($urandom_range(0, 23));
      else addr = 10'($urandom);
      send_req(act, addr, 16'($urandom), pick_shift());
      idle_gap();
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("requests: %0d read, %0d write, %0d flush, %0d remap, %0d clear; %0d cache hits",
             act_seen[swl_pkg::ACT_READ], act_seen[swl_pkg::ACT_WRITE],
             act_seen[swl_pkg::ACT_FLUSH], act_seen[swl_pkg::ACT_REMAP],
             act_seen[swl_pkg::ACT_CLEAR], hits_seen);
    $display("cycles: %0d, mismatches: %0d", cycles, fail_count);
    if (fail_count == 0) begin
      $display("shift_wear_leveler_with_write_cache test passed");
    end else begin
      $display("shift_wear_leveler_with_write_cache test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/swl_pkg.sv
hdl/shift_wear_leveler_with_write_cache.sv
sim/swl_checker.sv
sim/tb.sv
